// ===== hw/rtl/d8fa_pkg.sv =====
// Package for the D8 flow accumulation block.
// Holds the shared constants, the direction tables and the sequencer state type.
// It depends on nothing else.
package d8fa_pkg;

    localparam int DEF_MAX_GRID_WIDTH  = 64;
    localparam int DEF_MAX_GRID_HEIGHT = 64;
    localparam int DEF_HEIGHT_BITS     = 24;

    localparam int CFG_W  = 7;
    localparam int IDX_W  = 12;
    localparam int ACT_W  = 2;
    localparam int DIR_W  = 4;
    localparam int FLOW_W = 13;
    localparam int DEG_W  = 4;

    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    localparam logic [DIR_W-1:0]  DIR_NONE = 4'd8;
    localparam logic [FLOW_W-1:0] FLOW_ONE = 13'd1;
    localparam logic [FLOW_W-1:0] FLOW_MAX = 13'd8191;

    localparam int SCALE_CARD = 1414;
    localparam int SCALE_DIAG = 1000;

    // Neighbor steps, N first and then clockwise.
    localparam int STEP_COL [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int STEP_ROW [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

    typedef struct packed {
        logic       clear;
        logic       load_center;
        logic       nb_valid;
        logic [2:0] nb_dir;
    } t_slope_ctl;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RDW,
        S_INIT,
        S_DIR,
        S_IDG_RD,
        S_IDG_CHK,
        S_IDG_WR,
        S_SEED_RD,
        S_SEED_CHK,
        S_WLK_RD,
        S_WLK_CELL,
        S_WLK_DIR,
        S_WLK_TGT
    } t_state;

endpackage

// ===== hw/rtl/d8_flow_accumulation_top.sv =====
// Top level of the D8 flow accumulation block: sequencer, grid memories and ports.
// Depends on d8fa_pkg, d8fa_ram and d8fa_slope.
//
//   channel   direction   handshake                  payload
//   input     in          i_in_valid / o_in_stall    i_action, i_cell_index, i_height
//   result    out         o_out_valid / i_out_stall  o_flow_count, o_direction, o_error
//   config    in          i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// After reset a clearing pass writes every entry of the height, direction and
// flow memories, one per cycle, MAX_GRID_WIDTH * MAX_GRID_HEIGHT entries in all
// (4096 by default); no transaction is taken meanwhile. A load is answered from
// the idle state; a read waits in S_RDW for the registered memory read. A compute
// item first resets the direction, flow and in-degree stores of all W*H cells,
// then finds the drain direction of each interior cell through the single height
// read port and the shared slope unit, then runs the in-degree, seeding and queue
// walk passes. The input is stalled while a transaction is in work or the result
// register is full and stalled; results are held stable under i_out_stall.
module d8_flow_accumulation_top #(
    parameter int MAX_GRID_WIDTH  = d8fa_pkg::DEF_MAX_GRID_WIDTH,
    parameter int MAX_GRID_HEIGHT = d8fa_pkg::DEF_MAX_GRID_HEIGHT,
    parameter int HEIGHT_BITS     = d8fa_pkg::DEF_HEIGHT_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [d8fa_pkg::ACT_W-1:0]  i_action,
    input  logic [d8fa_pkg::IDX_W-1:0]  i_cell_index,
    input  logic [HEIGHT_BITS-1:0]      i_height,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [d8fa_pkg::FLOW_W-1:0] o_flow_count,
    output logic [d8fa_pkg::DIR_W-1:0]  o_direction,
    output logic                        o_error,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [d8fa_pkg::CFG_W-1:0]  i_cfg_data
);
    import d8fa_pkg::*;

    localparam int DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OW    = AW + 2;
    localparam int WW    = $clog2(MAX_GRID_WIDTH + 1);
    localparam int HW    = $clog2(MAX_GRID_HEIGHT + 1);

    // Address of the neighbor of base in direction d for a grid w columns wide.
    function automatic logic [AW-1:0] f_nb(input logic [AW-1:0] base,
                                           input logic [2:0] d,
                                           input logic [WW-1:0] w);
        logic signed [OW-1:0] sw;
        logic signed [OW-1:0] off;
        logic [OW-1:0]        sum;
        sw = signed'(OW'(w));
        if (STEP_ROW[d] < 0) begin
            off = -sw;
        end else if (STEP_ROW[d] > 0) begin
            off = sw;
        end else begin
            off = '0;
        end
        off = off + OW'(STEP_COL[d]);
        sum = OW'(base) + off;
        return sum[AW-1:0];
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] r_gw, r_gh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= CFG_RESET;
            r_gh <= CFG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_GRID_WIDTH) begin
                r_gw <= i_cfg_data;
            end else begin
                r_gh <= i_cfg_data;
            end
        end
    end

    // Grid size in use, saturated to 3 .. maximum.
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] n_cells;

    always_comb begin
        if (r_gw < CFG_W'(3)) begin
            w_eff = WW'(3);
        end else if (32'(r_gw) > 32'(MAX_GRID_WIDTH)) begin
            w_eff = WW'(MAX_GRID_WIDTH);
        end else begin
            w_eff = WW'(r_gw);
        end
        if (r_gh < CFG_W'(3)) begin
            h_eff = HW'(3);
        end else if (32'(r_gh) > 32'(MAX_GRID_HEIGHT)) begin
            h_eff = HW'(MAX_GRID_HEIGHT);
        end else begin
            h_eff = HW'(r_gh);
        end
        n_cells = CW'(32'(w_eff) * 32'(h_eff));
    end

    // Sequencer registers.
    t_state            r_state, n_state;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_tail, n_tail;
    logic [3:0]        r_k, n_k;
    logic [WW-1:0]     r_col, n_col;
    logic [HW-1:0]     r_row, n_row;
    logic [AW-1:0]     r_here, n_here;
    logic [AW-1:0]     r_cell, n_cell;
    logic [AW-1:0]     r_tgt, n_tgt;
    logic [FLOW_W-1:0] r_fc, n_fc;
    logic              r_out_valid, n_out_valid;
    logic [FLOW_W-1:0] r_flow, n_flow;
    logic [DIR_W-1:0]  r_dir, n_dir;
    logic              r_err, n_err;

    // Memory ports.
    logic                   h_we;
    logic [AW-1:0]          h_waddr, h_raddr;
    logic [HEIGHT_BITS-1:0] h_wdata, h_rdata;
    logic                   d_we;
    logic [AW-1:0]          d_waddr, d_raddr;
    logic [DIR_W-1:0]       d_wdata, d_rdata;
    logic                   f_we;
    logic [AW-1:0]          f_waddr, f_raddr;
    logic [FLOW_W-1:0]      f_wdata, f_rdata;
    logic                   g_we;
    logic [AW-1:0]          g_waddr, g_raddr;
    logic [DEG_W-1:0]       g_wdata, g_rdata;
    logic                   o_we;
    logic [AW-1:0]          o_waddr, o_raddr;
    logic [AW-1:0]          o_wdata, o_rdata;

    t_slope_ctl       slope_ctl;
    logic [DIR_W-1:0] steep_dir;

    logic          in_ready;
    logic          in_take;
    logic          idx_bad;
    logic [AW-1:0] idx_addr;
    logic [FLOW_W:0] flow_sum;

    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || !i_out_stall);
    assign in_take  = i_in_valid && in_ready;
    assign idx_bad  = 32'(i_cell_index) >= 32'(n_cells);
    assign idx_addr = AW'(i_cell_index);
    assign flow_sum = (FLOW_W + 1)'(f_rdata) + (FLOW_W + 1)'(r_fc);

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_head      = r_head;
        n_tail      = r_tail;
        n_k         = r_k;
        n_col       = r_col;
        n_row       = r_row;
        n_here      = r_here;
        n_cell      = r_cell;
        n_tgt       = r_tgt;
        n_fc        = r_fc;
        n_out_valid = r_out_valid && i_out_stall;
        n_flow      = r_flow;
        n_dir       = r_dir;
        n_err       = r_err;

        h_we = 1'b0; h_waddr = idx_addr; h_wdata = i_height; h_raddr = r_here;
        d_we = 1'b0; d_waddr = r_i[AW-1:0]; d_wdata = DIR_NONE; d_raddr = idx_addr;
        f_we = 1'b0; f_waddr = r_i[AW-1:0]; f_wdata = FLOW_ONE; f_raddr = idx_addr;
        g_we = 1'b0; g_waddr = r_i[AW-1:0]; g_wdata = '0; g_raddr = r_tgt;
        o_we = 1'b0; o_waddr = r_tail[AW-1:0]; o_wdata = r_i[AW-1:0];
        o_raddr = r_head[AW-1:0];

        slope_ctl = '0;

        case (r_state)
            S_CLR: begin
                h_we    = 1'b1;
                h_waddr = r_i[AW-1:0];
                h_wdata = '0;
                d_we    = 1'b1;
                f_we    = 1'b1;
                if (r_i == CW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
                n_i = r_i + 1'b1;
            end
            S_IDLE: begin
                if (in_take) begin
                    if (i_action == ACT_READ && !idx_bad) begin
                        n_state = S_RDW;
                    end else begin
                        n_out_valid = 1'b1;
                        n_flow      = '0;
                        n_dir       = DIR_NONE;
                        n_err       = (i_action == ACT_LOAD || i_action == ACT_READ)
                                      && idx_bad;
                        if (i_action == ACT_LOAD && !idx_bad) begin
                            h_we = 1'b1;
                        end
                        if (i_action == ACT_COMPUTE) begin
                            n_state = S_INIT;
                            n_i     = '0;
                        end
                    end
                end
            end
            S_RDW: begin
                n_out_valid = 1'b1;
                n_flow      = f_rdata;
                n_dir       = d_rdata;
                n_err       = 1'b0;
                n_state     = S_IDLE;
            end
            S_INIT: begin
                d_we = 1'b1;
                f_we = 1'b1;
                g_we = 1'b1;
                n_i  = r_i + 1'b1;
                if (r_i == n_cells - 1'b1) begin
                    n_state = S_DIR;
                    n_k     = '0;
                    n_row   = HW'(1);
                    n_col   = WW'(1);
                    n_here  = AW'(w_eff) + 1'b1;
                end
            end
            S_DIR: begin
                // Center read at step 0, neighbors at steps 1..8; the memory registers the read
                // data, and the slope unit has two stages of its own.
                if (r_k == 4'd0) begin
                    h_raddr = r_here;
                end else begin
                    h_raddr = f_nb(r_here, 3'(r_k - 4'd1), w_eff);
                end
                slope_ctl.clear       = (r_k == 4'd0);
                slope_ctl.load_center = (r_k == 4'd1);
                slope_ctl.nb_valid    = (r_k >= 4'd2) && (r_k <= 4'd9);
                slope_ctl.nb_dir      = 3'(r_k - 4'd2);
                n_k = r_k + 1'b1;
                if (r_k == 4'd11) begin
                    d_we    = 1'b1;
                    d_waddr = r_here;
                    d_wdata = steep_dir;
                    n_k     = '0;
                    if (r_col == w_eff - WW'(2)) begin
                        if (r_row == h_eff - HW'(2)) begin
                            n_state = S_IDG_RD;
                            n_i     = '0;
                        end else begin
                            n_row  = r_row + 1'b1;
                            n_col  = WW'(1);
                            n_here = r_here + AW'(3);
                        end
                    end else begin
                        n_col  = r_col + 1'b1;
                        n_here = r_here + 1'b1;
                    end
                end
            end
            S_IDG_RD: begin
                d_raddr = r_i[AW-1:0];
                if (r_i == n_cells) begin
                    n_state = S_SEED_RD;
                    n_i     = '0;
                    n_tail  = '0;
                end else begin
                    n_state = S_IDG_CHK;
                end
            end
            S_IDG_CHK: begin
                if (d_rdata == DIR_NONE) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_IDG_RD;
                end else begin
                    n_tgt   = f_nb(r_i[AW-1:0], d_rdata[2:0], w_eff);
                    g_raddr = n_tgt;
                    n_state = S_IDG_WR;
                end
            end
            S_IDG_WR: begin
                g_we    = 1'b1;
                g_waddr = r_tgt;
                g_wdata = g_rdata + 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_IDG_RD;
            end
            S_SEED_RD: begin
                g_raddr = r_i[AW-1:0];
                if (r_i == n_cells) begin
                    n_state = S_WLK_RD;
                    n_head  = '0;
                end else begin
                    n_state = S_SEED_CHK;
                end
            end
            S_SEED_CHK: begin
                // Cells that nothing drains into start the walk queue.
                if (g_rdata == '0) begin
                    o_we   = 1'b1;
                    n_tail = r_tail + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = S_SEED_RD;
            end
            S_WLK_RD: begin
                o_raddr = r_head[AW-1:0];
                if (r_head == r_tail) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WLK_CELL;
                end
            end
            S_WLK_CELL: begin
                n_cell  = o_rdata;
                d_raddr = o_rdata;
                f_raddr = o_rdata;
                n_state = S_WLK_DIR;
            end
            S_WLK_DIR: begin
                n_fc = f_rdata;
                if (d_rdata == DIR_NONE) begin
                    n_head  = r_head + 1'b1;
                    n_state = S_WLK_RD;
                end else begin
                    n_tgt   = f_nb(r_cell, d_rdata[2:0], w_eff);
                    f_raddr = n_tgt;
                    g_raddr = n_tgt;
                    n_state = S_WLK_TGT;
                end
            end
            S_WLK_TGT: begin
                // All upstream cells of a queued cell are done before it is queued.
                f_we    = 1'b1;
                f_waddr = r_tgt;
                f_wdata = (flow_sum > (FLOW_W + 1)'(FLOW_MAX)) ? FLOW_MAX
                                                               : flow_sum[FLOW_W-1:0];
                g_we    = 1'b1;
                g_waddr = r_tgt;
                g_wdata = g_rdata - 1'b1;
                if (g_rdata == DEG_W'(1)) begin
                    o_we    = 1'b1;
                    o_wdata = r_tgt;
                    n_tail  = r_tail + 1'b1;
                end
                n_head  = r_head + 1'b1;
                n_state = S_WLK_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
        r_k    <= n_k;
        r_col  <= n_col;
        r_row  <= n_row;
        r_here <= n_here;
        r_cell <= n_cell;
        r_tgt  <= n_tgt;
        r_fc   <= n_fc;
        r_flow <= n_flow;
        r_dir  <= n_dir;
        r_err  <= n_err;
    end

    d8fa_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_height (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    d8fa_ram #(.WIDTH(DIR_W), .DEPTH(DEPTH)) u_dir (
        .i_clk(i_clk), .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wdata),
        .i_raddr(d_raddr), .o_rdata(d_rdata)
    );

    d8fa_ram #(.WIDTH(FLOW_W), .DEPTH(DEPTH)) u_flow (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    d8fa_ram #(.WIDTH(DEG_W), .DEPTH(DEPTH)) u_indeg (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(g_rdata)
    );

    d8fa_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_order (
        .i_clk(i_clk), .i_we(o_we), .i_waddr(o_waddr), .i_wdata(o_wdata),
        .i_raddr(o_raddr), .o_rdata(o_rdata)
    );

    d8fa_slope #(.HEIGHT_BITS(HEIGHT_BITS)) u_slope (
        .i_clk(i_clk), .i_ctl(slope_ctl), .i_height(h_rdata), .o_steep_dir(steep_dir)
    );

    assign o_in_stall   = !in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_flow_count = r_flow;
    assign o_direction  = r_dir;
    assign o_error      = r_err;

endmodule

// ===== hw/rtl/d8fa_ram.sv =====
// Simple dual-port memory: one write port and one read port with registered data.
// Uses no package.
module d8fa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/d8fa_slope.sv =====
// Shared slope unit: scales one neighbor drop per cycle and keeps the steepest one.
// Depends on d8fa_pkg.
module d8fa_slope #(
    parameter int HEIGHT_BITS = 24
) (
    input  logic                       i_clk,
    input  d8fa_pkg::t_slope_ctl       i_ctl,
    input  logic [HEIGHT_BITS-1:0]     i_height,
    output logic [d8fa_pkg::DIR_W-1:0] o_steep_dir
);
    import d8fa_pkg::*;

    localparam int DW = HEIGHT_BITS + 1;
    localparam int PW = DW + 12;

    logic signed [HEIGHT_BITS-1:0] r_center;
    logic signed [PW-1:0]          r_prod;
    logic [2:0]                    r_pdir;
    logic                          r_pvalid;
    logic signed [PW-1:0]          r_best;
    logic [DIR_W-1:0]              r_steep_dir;

    logic signed [DW-1:0] drop;
    logic signed [PW-1:0] scale;

    always_comb begin
        drop  = DW'(r_center) - DW'(signed'(i_height));
        scale = i_ctl.nb_dir[0] ? PW'(SCALE_DIAG) : PW'(SCALE_CARD);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_center) begin
            r_center <= signed'(i_height);
        end
        r_prod   <= PW'(drop) * scale;
        r_pdir   <= i_ctl.nb_dir;
        r_pvalid <= i_ctl.nb_valid;
        if (i_ctl.clear) begin
            r_best      <= '0;
            r_steep_dir <= DIR_NONE;
        end else if (r_pvalid && (r_prod > r_best)) begin
            // Strictly greater, so the first maximum in scan order wins.
            r_best      <= r_prod;
            r_steep_dir <= DIR_W'(r_pdir);
        end
    end

    assign o_steep_dir = r_steep_dir;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the D8 flow accumulation block.
// Depends on d8fa_pkg and d8_flow_accumulation_top. It drives random and
// directed transactions and checks each result against a behavioral grid model.
module tb_top;
    import d8fa_pkg::*;

    localparam int CELL_CAP = DEF_MAX_GRID_WIDTH * DEF_MAX_GRID_HEIGHT;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic [DIR_W-1:0]  dir;
        logic              err;
    } t_cell_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [ACT_W-1:0]     i_action;
    logic [IDX_W-1:0]     i_cell_index;
    logic [23:0]          i_height;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [FLOW_W-1:0]    o_flow_count;
    logic [DIR_W-1:0]     o_direction;
    logic                 o_error;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    d8_flow_accumulation_top i_dut (.*);

    // Behavioral copy of the grid: heights, drain directions, flows and the
    // walk order, plus the raw configuration register values.
    logic signed [23:0]   terrain [CELL_CAP];
    logic [DIR_W-1:0]     drain_dir [CELL_CAP];
    logic [FLOW_W-1:0]    flow_acc [CELL_CAP];
    int                   walk_order [CELL_CAP];
    int                   merge_buf [CELL_CAP];
    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;

    t_cell_answer         pending_answers [$];
    int                   fail_count;
    int                   items_sent;
    bit                   quiet;
    int                   stall_left;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Cell a is walked before cell b: higher first, lower index on a tie.
    function automatic bit walks_first(int a, int b);
        if (terrain[a] != terrain[b]) return terrain[a] > terrain[b];
        return a < b;
    endfunction

    task automatic sort_by_height(int n);
        int run, lo, mid, hi, p, q, k;
        for (int i = 0; i < n; i++) walk_order[i] = i;
        for (run = 1; run < n; run *= 2) begin
            for (lo = 0; lo < n; lo += 2 * run) begin
                mid = (lo + run < n) ? lo + run : n;
                hi  = (lo + 2 * run < n) ? lo + 2 * run : n;
                p = lo; q = mid; k = lo;
                while (p < mid && q < hi) begin
                    if (walks_first(walk_order[q], walk_order[p])) begin
                        merge_buf[k] = walk_order[q]; q++;
                    end else begin
                        merge_buf[k] = walk_order[p]; p++;
                    end
                    k++;
                end
                while (p < mid) begin merge_buf[k] = walk_order[p]; p++; k++; end
                while (q < hi) begin merge_buf[k] = walk_order[q]; q++; k++; end
            end
            for (int i = 0; i < n; i++) walk_order[i] = merge_buf[i];
        end
    endtask

    task automatic accumulate_flow(int w, int h);
        int n, here, nb, src, tr, tc, sum;
        longint best, scaled;
        logic [DIR_W-1:0] steep_dir;
        n = w * h;
        for (int i = 0; i < n; i++) begin
            drain_dir[i] = DIR_NONE;
            flow_acc[i] = FLOW_ONE;
        end
        for (int r = 1; r + 1 < h; r++) begin
            for (int c = 1; c + 1 < w; c++) begin
                here = r * w + c;
                best = 0;
                steep_dir = DIR_NONE;
                for (int d = 0; d < 8; d++) begin
                    nb = (r + STEP_ROW[d]) * w + c + STEP_COL[d];
                    scaled = (longint'(terrain[here]) - longint'(terrain[nb]))
                           * ((d % 2) ? SCALE_DIAG : SCALE_CARD);
                    if (scaled > best) begin
                        best = scaled;
                        steep_dir = d[DIR_W-1:0];
                    end
                end
                drain_dir[here] = steep_dir;
            end
        end
        sort_by_height(n);
        for (int i = 0; i < n; i++) begin
            src = walk_order[i];
            if (drain_dir[src] != DIR_NONE) begin
                tr = src / w + STEP_ROW[drain_dir[src]];
                tc = src % w + STEP_COL[drain_dir[src]];
                sum = int'(flow_acc[tr * w + tc]) + int'(flow_acc[src]);
                flow_acc[tr * w + tc] = (sum > FLOW_MAX) ? FLOW_MAX : sum[FLOW_W-1:0];
            end
        end
    endtask

    // Applies one accepted transaction to the grid copy and returns its answer.
    task automatic predict_cell(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                                input logic [23:0] hgt, output t_cell_answer ans);
        int w, h;
        w = clamp_dim(width_reg, DEF_MAX_GRID_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_GRID_HEIGHT);
        ans = '{flow: '0, dir: DIR_NONE, err: 1'b0};
        if (act == ACT_LOAD || act == ACT_READ) begin
            if (int'(idx) >= w * h) ans.err = 1'b1;
            else if (act == ACT_LOAD) terrain[idx] = hgt;
            else begin
                ans.flow = flow_acc[idx];
                ans.dir = drain_dir[idx];
            end
        end else if (act == ACT_COMPUTE) begin
            accumulate_flow(w, h);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one transaction and records its expected answer once accepted.
    task automatic send_item(logic [ACT_W-1:0] act, logic [IDX_W-1:0] idx, logic [23:0] hgt);
        t_cell_answer ans;
        int gap;
        i_action <= act;
        i_cell_index <= idx;
        i_height <= hgt;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_cell(act, idx, hgt, ans);
        pending_answers.push_back(ans);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Registers are only written once the block has answered everything and
    // has finished any compute that is still running.
    task automatic write_grid_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending_answers.size() != 0 || o_in_stall) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_GRID_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_GRID_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
    endtask

    // Loads a 3x3 grid from a list of nine heights, computes, and reads back.
    task automatic run_tiny_grid(logic [23:0] hs [9]);
        for (int i = 0; i < 9; i++) send_item(ACT_LOAD, i[IDX_W-1:0], hs[i]);
        send_item(ACT_COMPUTE, '0, '0);
        send_item(ACT_READ, 12'd4, '0);
        send_item(ACT_READ, 12'd1, '0);
    endtask

    task automatic test_directed();
        logic [23:0] hs [9];
        write_grid_size(7'd3, 7'd3);
        // Extreme heights: the center is highest, corners lowest.
        hs = '{24'h800000, 24'h000100, 24'h800000, 24'hFFFF00, 24'h7FFFFF,
               24'h000000, 24'h800000, 24'h000001, 24'h800000};
        run_tiny_grid(hs);
        // A cardinal and a diagonal drop of exactly equal slope: north wins.
        hs = '{24'd2828, 24'd1828, 24'd1414, 24'd2828, 24'd2828,
               24'd2828, 24'd2828, 24'd2828, 24'd2828};
        run_tiny_grid(hs);
        // Out-of-grid load and read, the unused action, and a flat grid.
        send_item(ACT_LOAD, 12'd4095, 24'h123456);
        send_item(ACT_READ, 12'd9, '0);
        send_item(ACT_UNUSED, 12'd4, 24'hFFFFFF);
        for (int i = 0; i < 9; i++) send_item(ACT_LOAD, i[IDX_W-1:0], 24'h000500);
        send_item(ACT_COMPUTE, '0, '0);
        send_item(ACT_READ, 12'd4, '0);
    endtask

    function automatic logic [23:0] random_height();
        if ($urandom_range(0, 3) == 0) return 24'($urandom());
        return 24'($urandom_range(0, 40) - 20);
    endfunction

    // One phase: loads, a compute, reads, with a little noise mixed in.
    task automatic run_phase(int loads, int reads);
        int w, h, n, r;
        w = clamp_dim(width_reg, DEF_MAX_GRID_WIDTH);
        h = clamp_dim(height_reg, DEF_MAX_GRID_HEIGHT);
        n = w * h;
        for (int i = 0; i < loads; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) send_item(ACT_LOAD, IDX_W'($urandom()), 24'($urandom()));
            else if (r < 6) send_item(ACT_UNUSED, IDX_W'($urandom()), 24'($urandom()));
            else send_item(ACT_LOAD, IDX_W'($urandom_range(0, n - 1)), random_height());
        end
        send_item(ACT_COMPUTE, IDX_W'($urandom()), 24'($urandom()));
        for (int i = 0; i < reads; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) send_item(ACT_READ, IDX_W'($urandom()), 24'($urandom()));
            else if (r < 6) send_item(ACT_UNUSED, IDX_W'($urandom()), 24'($urandom()));
            else send_item(ACT_READ, IDX_W'($urandom_range(0, n - 1)), 24'($urandom()));
        end
    endtask

    task automatic test_extreme_sizes();
        write_grid_size(7'd64, 7'd64);
        run_phase(40, 40);
        write_grid_size(7'd3, 7'd64);
        run_phase(120, 60);
        write_grid_size(7'd64, 7'd3);
        run_phase(120, 60);
        // Register values outside the legal range saturate.
        write_grid_size(7'd127, 7'd0);
        run_phase(30, 30);
        write_grid_size(7'd2, 7'd100);
        run_phase(30, 30);
    endtask

    task automatic test_random_grids();
        int w, h;
        while (items_sent < 1650) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 12);
            quiet = ($urandom_range(0, 4) == 0);
            write_grid_size(w[CFG_W-1:0], h[CFG_W-1:0]);
            run_phase(w * h + $urandom_range(0, 8), $urandom_range(10, 40));
        end
        quiet = 1'b0;
    endtask

    // Result stall: mostly free, occasionally held for a short or long run.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    i_out_stall <= 1'b1;
                    stall_left <= $urandom_range(0, 2);
                end
                3: begin
                    i_out_stall <= 1'b1;
                    stall_left <= $urandom_range(8, 30);
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    // Every accepted result transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_cell_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: result with nothing expected: flow %0d dir %0d err %0d",
                         $time, o_flow_count, o_direction, o_error);
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_flow_count !== want.flow) begin
                    $display("%0t: flow_count expected %0d actual %0d",
                             $time, want.flow, o_flow_count);
                    fail_count++;
                end
                if (o_direction !== want.dir) begin
                    $display("%0t: direction expected %0d actual %0d",
                             $time, want.dir, o_direction);
                    fail_count++;
                end
                if (o_error !== want.err) begin
                    $display("%0t: error expected %0d actual %0d",
                             $time, want.err, o_error);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        items_sent = 0;
        quiet = 1'b0;
        stall_left = 0;
        width_reg = CFG_RESET;
        height_reg = CFG_RESET;
        for (int i = 0; i < CELL_CAP; i++) begin
            terrain[i] = '0;
            drain_dir[i] = DIR_NONE;
            flow_acc[i] = FLOW_ONE;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_LOAD;
        i_cell_index = '0;
        i_height = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_GRID_WIDTH;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extreme_sizes();
        test_random_grids();

        // Drain the last results, then allow a few more cycles for strays.
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
